[hdl/rsc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rsc_pkg
// Shared constants and types of the reduced surrogate crossover block.
// ----------------------------------------------------------------------------
package rsc_pkg;

  // random word width and per-stage step of the remainder pipeline
  localparam int PICK_W   = 32;
  localparam int MOD_STEP = 8;

  // cut position field width
  localparam int CUT_W = 6;

  // difference word is handled in byte lanes
  localparam int LANE_BIT_W = 3;
  localparam int LANE_W     = 1 << LANE_BIT_W;
  localparam int LCNT_W     = LANE_BIT_W + 1;

  // configuration register
  localparam int NUM_BITS_W = 7;
  localparam logic [NUM_BITS_W-1:0] NUM_BITS_RESET = 7'd64;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam logic REG_NUM_BITS = 1'b0;

  // queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } rsc_q_status_t;

endpackage : rsc_pkg
`default_nettype wire

[hdl/reduced_surrogate_crossover.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// reduced_surrogate_crossover
// Reduced surrogate one-point crossover of two gene words per transaction.
// ----------------------------------------------------------------------------
// Takes one parent pair per clock and delivers one child per clock as long as
// the output side keeps up; the rate is set by the front pipeline (mask, lane
// popcount, then a remainder unit that retires eight bits of the random word
// per stage) and the two back stages (lane search, bit search with child
// build), each of which handles a new transaction every cycle. With an empty
// queue a transaction passes nine registers: six front stages, the queue entry
// and the two back stages, the second of which is the output register. A
// four-entry queue lets the front keep accepting while the output is stalled.
// num_bits lives at byte address 0 of the configuration port and is to be
// changed only when no transaction is in flight.
// ----------------------------------------------------------------------------
module reduced_surrogate_crossover
  import rsc_pkg::*;
#(
  parameter int WORD_BITS = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // fields from bit 0: parent_a, parent_b, random_pick, parent_order, zero fill
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [((2*WORD_BITS+PICK_W+1+7)/8)*8-1:0] in_tdata,
  // fields from bit 0: child_word, cut_position, parents_identical, zero fill
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [((WORD_BITS+CUT_W+1+7)/8)*8-1:0] out_tdata,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [APB_ADDR_W-1:0] cfg_paddr,
  input  wire logic [APB_DATA_W-1:0] cfg_pwdata,
  output logic [APB_DATA_W-1:0]      cfg_prdata,
  output logic                       cfg_pready
);

  localparam int OUT_RAW = WORD_BITS + CUT_W + 1;
  localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;
  localparam int CNT_W   = $clog2(WORD_BITS + 1);
  localparam int NLANE   = (WORD_BITS + LANE_W - 1) / LANE_W;
  localparam int LC_W    = NLANE * LCNT_W;
  localparam int E_W     = 2 * WORD_BITS + LC_W + CNT_W + 2;

  logic [NUM_BITS_W-1:0] num_bits_r;

  rsc_q_status_t         q_status;
  logic                  push, pop;
  logic [E_W-1:0]        push_data, pop_data;

  logic [WORD_BITS-1:0]  f_a, f_diff, b_a, b_diff;
  logic [LC_W-1:0]       f_lcnt, b_lcnt;
  logic [CNT_W-1:0]      f_rank, b_rank;
  logic                  f_order, f_ident, b_order, b_ident;

  logic [WORD_BITS-1:0]  child_word;
  logic [CUT_W-1:0]      cut_position;
  logic                  parents_identical;

  // configuration register
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_bits_r <= NUM_BITS_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 (cfg_paddr[2] == REG_NUM_BITS)) begin
      num_bits_r <= cfg_pwdata[NUM_BITS_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == REG_NUM_BITS) begin
      cfg_prdata = APB_DATA_W'(num_bits_r);
    end
  end

  // front: accept and classify
  rsc_front #(
    .WORD_BITS (WORD_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .num_bits     (num_bits_r),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .parent_a     (in_tdata[WORD_BITS-1:0]),
    .parent_b     (in_tdata[2*WORD_BITS-1:WORD_BITS]),
    .random_pick  (in_tdata[2*WORD_BITS+PICK_W-1:2*WORD_BITS]),
    .parent_order (in_tdata[2*WORD_BITS+PICK_W]),
    .q_status     (q_status),
    .push         (push),
    .push_a       (f_a),
    .push_diff    (f_diff),
    .push_lcnt    (f_lcnt),
    .push_rank    (f_rank),
    .push_order   (f_order),
    .push_ident   (f_ident)
  );

  // queue between front and back
  assign push_data = {f_ident, f_order, f_rank, f_lcnt, f_diff, f_a};
  assign {b_ident, b_order, b_rank, b_lcnt, b_diff, b_a} = pop_data;

  rsc_queue #(
    .DATA_W (E_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (q_status)
  );

  // back: cut search and child build
  rsc_back #(
    .WORD_BITS (WORD_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_status          (q_status),
    .pop               (pop),
    .q_a               (b_a),
    .q_diff            (b_diff),
    .q_lcnt            (b_lcnt),
    .q_rank            (b_rank),
    .q_order           (b_order),
    .q_ident           (b_ident),
    .out_valid         (out_tvalid),
    .out_ready         (out_tready),
    .child_word        (child_word),
    .cut_position      (cut_position),
    .parents_identical (parents_identical)
  );

  assign out_tdata = OUT_W'({parents_identical, cut_position, child_word});

endmodule : reduced_surrogate_crossover
`default_nettype wire

[hdl/rsc_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rsc_front
// Accepts parent words, masks them, counts differing bits per byte lane and
// reduces the random word modulo the count in a pipelined remainder unit.
// ----------------------------------------------------------------------------
module rsc_front
  import rsc_pkg::*;
#(
  parameter int WORD_BITS = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic [NUM_BITS_W-1:0] num_bits,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [WORD_BITS-1:0]  parent_a,
  input  wire logic [WORD_BITS-1:0]  parent_b,
  input  wire logic [PICK_W-1:0]     random_pick,
  input  wire logic                  parent_order,
  input  wire rsc_q_status_t         q_status,
  output logic                       push,
  output logic [WORD_BITS-1:0]       push_a,
  output logic [WORD_BITS-1:0]       push_diff,
  output logic [((WORD_BITS+LANE_W-1)/LANE_W)*LCNT_W-1:0] push_lcnt,
  output logic [$clog2(WORD_BITS+1)-1:0] push_rank,
  output logic                       push_order,
  output logic                       push_ident
);

  localparam int CNT_W   = $clog2(WORD_BITS + 1);
  localparam int NLANE   = (WORD_BITS + LANE_W - 1) / LANE_W;
  localparam int PAD_W   = NLANE * LANE_W;
  localparam int MOD_STG = PICK_W / MOD_STEP;
  localparam int LAST    = MOD_STG - 1;

  logic                  adv;

  // stage 0: masked parents
  logic [NUM_BITS_W-1:0] width;
  logic [WORD_BITS-1:0]  mask;
  logic                  vld0_r;
  logic [WORD_BITS-1:0]  a0_r, d0_r;
  logic [PICK_W-1:0]     pk0_r;
  logic                  or0_r;

  // stage 1: lane counts and total
  logic [PAD_W-1:0]                   d0_pad;
  logic [NLANE-1:0][LCNT_W-1:0]       lc_nxt;
  logic [CNT_W-1:0]                   cnt_nxt;
  logic                               vld1_r;
  logic [WORD_BITS-1:0]               a1_r, d1_r;
  logic [PICK_W-1:0]                  pk1_r;
  logic                               or1_r;
  logic [CNT_W-1:0]                   cnt1_r;
  logic [NLANE-1:0][LCNT_W-1:0]       lc1_r;

  // remainder stages
  logic [MOD_STG-1:0]                 m_vld_r;
  logic [WORD_BITS-1:0]               m_a_r   [MOD_STG];
  logic [WORD_BITS-1:0]               m_d_r   [MOD_STG];
  logic [PICK_W-1:0]                  m_pk_r  [MOD_STG];
  logic                               m_or_r  [MOD_STG];
  logic [CNT_W-1:0]                   m_cnt_r [MOD_STG];
  logic [NLANE-1:0][LCNT_W-1:0]       m_lc_r  [MOD_STG];
  logic [CNT_W-1:0]                   m_rem_r [MOD_STG];
  logic [CNT_W-1:0]                   rem_nxt [MOD_STG];

  // whole front moves unless a finished entry waits on a full queue
  assign adv      = !(m_vld_r[LAST] && q_status.full);
  assign in_ready = adv;
  assign push     = m_vld_r[LAST] && !q_status.full;

  // valid width saturates at the word size
  always_comb begin
    width = (num_bits > NUM_BITS_W'(WORD_BITS)) ? NUM_BITS_W'(WORD_BITS) : num_bits;
    for (int i = 0; i < WORD_BITS; i++) begin
      mask[i] = NUM_BITS_W'(i) < width;
    end
  end

  // lane popcounts and total over the difference word
  always_comb begin
    d0_pad  = PAD_W'(d0_r);
    cnt_nxt = '0;
    for (int k = 0; k < NLANE; k++) begin
      lc_nxt[k] = '0;
      for (int j = 0; j < LANE_W; j++) begin
        lc_nxt[k] = lc_nxt[k] + LCNT_W'(d0_pad[k*LANE_W+j]);
      end
      cnt_nxt = cnt_nxt + CNT_W'(lc_nxt[k]);
    end
  end

  // restoring remainder, one byte of the random word per stage
  always_comb begin
    logic [CNT_W-1:0]  r;
    logic [CNT_W:0]    t;
    logic [CNT_W-1:0]  c;
    logic [PICK_W-1:0] p;
    for (int s = 0; s < MOD_STG; s++) begin
      if (s == 0) begin
        r = '0;
        c = cnt1_r;
        p = pk1_r;
      end else begin
        r = m_rem_r[s-1];
        c = m_cnt_r[s-1];
        p = m_pk_r[s-1];
      end
      for (int j = 0; j < MOD_STEP; j++) begin
        t = {r, p[PICK_W-1-MOD_STEP*s-j]};
        if (t >= {1'b0, c}) begin
          t = t - {1'b0, c};
        end
        r = t[CNT_W-1:0];
      end
      rem_nxt[s] = r;
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r  <= 1'b0;
      vld1_r  <= 1'b0;
      m_vld_r <= '0;
    end else if (adv) begin
      vld0_r  <= in_valid;
      vld1_r  <= vld0_r;
      m_vld_r <= {m_vld_r[MOD_STG-2:0], vld1_r};
    end
  end

  // payload chain
  always_ff @(posedge clk) begin
    if (adv) begin
      a0_r  <= parent_a & mask;
      d0_r  <= (parent_a ^ parent_b) & mask;
      pk0_r <= random_pick;
      or0_r <= parent_order;

      a1_r   <= a0_r;
      d1_r   <= d0_r;
      pk1_r  <= pk0_r;
      or1_r  <= or0_r;
      cnt1_r <= cnt_nxt;
      lc1_r  <= lc_nxt;

      m_a_r[0]   <= a1_r;
      m_d_r[0]   <= d1_r;
      m_pk_r[0]  <= pk1_r;
      m_or_r[0]  <= or1_r;
      m_cnt_r[0] <= cnt1_r;
      m_lc_r[0]  <= lc1_r;
      for (int s = 1; s < MOD_STG; s++) begin
        m_a_r[s]   <= m_a_r[s-1];
        m_d_r[s]   <= m_d_r[s-1];
        m_pk_r[s]  <= m_pk_r[s-1];
        m_or_r[s]  <= m_or_r[s-1];
        m_cnt_r[s] <= m_cnt_r[s-1];
        m_lc_r[s]  <= m_lc_r[s-1];
      end
      for (int s = 0; s < MOD_STG; s++) begin
        m_rem_r[s] <= rem_nxt[s];
      end
    end
  end

  // entry handed to the queue
  assign push_a     = m_a_r[LAST];
  assign push_diff  = m_d_r[LAST];
  assign push_lcnt  = m_lc_r[LAST];
  assign push_rank  = m_rem_r[LAST];
  assign push_order = m_or_r[LAST];
  assign push_ident = (m_cnt_r[LAST] == '0);

endmodule : rsc_front
`default_nettype wire

[hdl/rsc_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rsc_queue
// Short first-in first-out queue of classified entries between front and back.
// ----------------------------------------------------------------------------
module rsc_queue
  import rsc_pkg::*;
#(
  parameter int DATA_W = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire logic [DATA_W-1:0] push_data,
  input  wire logic              pop,
  output logic [DATA_W-1:0]      pop_data,
  output rsc_q_status_t          status
);

  logic [DATA_W-1:0]  mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign status.full  = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign status.empty = (cnt_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data = mem_r[rd_ptr_r];

endmodule : rsc_queue
`default_nettype wire

[hdl/rsc_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rsc_back
// Locates the differing bit of the chosen rank (byte lane, then bit) and
// builds the child word into the output register.
// ----------------------------------------------------------------------------
module rsc_back
  import rsc_pkg::*;
#(
  parameter int WORD_BITS = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire rsc_q_status_t        q_status,
  output logic                      pop,
  input  wire logic [WORD_BITS-1:0] q_a,
  input  wire logic [WORD_BITS-1:0] q_diff,
  input  wire logic [((WORD_BITS+LANE_W-1)/LANE_W)*LCNT_W-1:0] q_lcnt,
  input  wire logic [$clog2(WORD_BITS+1)-1:0] q_rank,
  input  wire logic                 q_order,
  input  wire logic                 q_ident,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [WORD_BITS-1:0]      child_word,
  output logic [CUT_W-1:0]          cut_position,
  output logic                      parents_identical
);

  localparam int CNT_W   = $clog2(WORD_BITS + 1);
  localparam int NLANE   = (WORD_BITS + LANE_W - 1) / LANE_W;
  localparam int PAD_W   = NLANE * LANE_W;
  localparam int LANE_IW = (NLANE > 1) ? $clog2(NLANE) : 1;

  logic                         adv;
  logic [NLANE-1:0][LCNT_W-1:0] lc;

  // lane search
  logic [LANE_IW-1:0]    lane_nxt;
  logic [LANE_BIT_W-1:0] resid_nxt;

  logic                  b1_vld_r;
  logic [WORD_BITS-1:0]  b1_a_r, b1_d_r;
  logic [LANE_IW-1:0]    b1_lane_r;
  logic [LANE_BIT_W-1:0] b1_resid_r;
  logic                  b1_order_r, b1_ident_r;

  // bit search and child
  logic [NLANE-1:0][LANE_W-1:0] d_lanes;
  logic [LANE_BIT_W-1:0]        bit_nxt;
  logic [CUT_W-1:0]             cut_nxt;
  logic [WORD_BITS-1:0]         below;
  logic [WORD_BITS-1:0]         child_nxt;

  logic                  out_vld_r;
  logic [WORD_BITS-1:0]  child_r;
  logic [CUT_W-1:0]      cut_r;
  logic                  ident_r;

  assign adv = !out_vld_r || out_ready;
  assign pop = adv && !q_status.empty;
  assign lc  = q_lcnt;

  // first lane whose running count passes the rank
  always_comb begin
    logic [CNT_W:0] cum;
    logic [CNT_W:0] top;
    logic           found;
    cum       = '0;
    found     = 1'b0;
    lane_nxt  = '0;
    resid_nxt = '0;
    for (int k = 0; k < NLANE; k++) begin
      top = cum + (CNT_W+1)'(lc[k]);
      if (!found && ({1'b0, q_rank} < top)) begin
        found     = 1'b1;
        lane_nxt  = LANE_IW'(k);
        resid_nxt = LANE_BIT_W'({1'b0, q_rank} - cum);
      end
      cum = top;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_vld_r <= 1'b0;
    end else if (adv) begin
      b1_vld_r <= !q_status.empty;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b1_a_r     <= q_a;
      b1_d_r     <= q_diff;
      b1_lane_r  <= lane_nxt;
      b1_resid_r <= resid_nxt;
      b1_order_r <= q_order;
      b1_ident_r <= q_ident;
    end
  end

  // bit of the remaining rank inside the chosen lane
  always_comb begin
    logic [LANE_W-1:0]     lb;
    logic [LANE_BIT_W-1:0] r;
    logic                  found;
    d_lanes = PAD_W'(b1_d_r);
    lb      = d_lanes[b1_lane_r];
    r       = b1_resid_r;
    found   = 1'b0;
    bit_nxt = '0;
    for (int j = 0; j < LANE_W; j++) begin
      if (lb[j] && !found) begin
        if (r == '0) begin
          found   = 1'b1;
          bit_nxt = LANE_BIT_W'(j);
        end else begin
          r = r - 1'b1;
        end
      end
    end
    cut_nxt = b1_ident_r ? '0 : CUT_W'({b1_lane_r, bit_nxt});
  end

  // differing bits flip to the other parent on the side the order selects
  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      below[i] = CUT_W'(i) < cut_nxt;
    end
    child_nxt = b1_a_r ^ (b1_d_r & (b1_order_r ? below : ~below));
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= b1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      child_r <= child_nxt;
      cut_r   <= cut_nxt;
      ident_r <= b1_ident_r;
    end
  end

  assign out_valid         = out_vld_r;
  assign child_word        = child_r;
  assign cut_position      = cut_r;
  assign parents_identical = ident_r;

endmodule : rsc_back
`default_nettype wire

[hdl/rsc_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rsc_checker
// Port-level checks of the crossover block, bound to the top level.
// ----------------------------------------------------------------------------
module rsc_checker
  import rsc_pkg::*;
#(
  parameter int WORD_BITS = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  out_tvalid,
  input  wire logic                  out_tready,
  input  wire logic [((WORD_BITS+CUT_W+1+7)/8)*8-1:0] out_tdata,
  input  wire logic [APB_DATA_W-1:0] cfg_prdata
);

  logic [NUM_BITS_W-1:0] width;
  logic [WORD_BITS-1:0]  mask;
  logic [WORD_BITS-1:0]  child;
  logic [CUT_W-1:0]      cut;
  logic                  ident;

  assign child = out_tdata[WORD_BITS-1:0];
  assign cut   = out_tdata[WORD_BITS+CUT_W-1:WORD_BITS];
  assign ident = out_tdata[WORD_BITS+CUT_W];

  // valid width as the register reads back
  always_comb begin
    width = (cfg_prdata[NUM_BITS_W-1:0] > NUM_BITS_W'(WORD_BITS)) ?
            NUM_BITS_W'(WORD_BITS) : cfg_prdata[NUM_BITS_W-1:0];
    for (int i = 0; i < WORD_BITS; i++) begin
      mask[i] = NUM_BITS_W'(i) < width;
    end
  end

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // reset empties the output
  a_out_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // identical parents report no cut
  a_ident_cut: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && ident |-> cut == '0)
    else $error("cut position set for identical parents");

  // child bits beyond the valid width are clear
  a_child_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (child & ~mask) == '0)
    else $error("child bits beyond valid width");

endmodule : rsc_checker

bind reduced_surrogate_crossover rsc_checker #(.WORD_BITS(WORD_BITS)) u_rsc_checker (.*);
`default_nettype wire

[sim/tb_reduced_surrogate_crossover.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_reduced_surrogate_crossover
// Self-checking bench for the reduced surrogate crossover block.
// ----------------------------------------------------------------------------
// A directed table covers the field extremes, identical parents, zero and
// oversized widths and both parent orders. Random parent pairs then run under
// a series of num_bits settings. Each accepted pair queues its expected child,
// from the table or, for random pairs and rows without one, a local crossover
// predictor. Every child that leaves the block is compared field by field with
// the oldest entry. Both stream sides idle at random, and the result side is
// held off once for a long stretch so that the block fills up and stalls.
// ----------------------------------------------------------------------------
module tb_reduced_surrogate_crossover;
  import rsc_pkg::*;

  localparam int WORD_BITS = 64;
  localparam int IN_W  = ((2*WORD_BITS+PICK_W+1+7)/8)*8;
  localparam int OUT_W = ((WORD_BITS+CUT_W+1+7)/8)*8;

  localparam logic [APB_ADDR_W-1:0] NUM_BITS_ADDR = APB_ADDR_W'(4 * REG_NUM_BITS);
  localparam logic [APB_ADDR_W-1:0] UNMAPPED_ADDR = 3'd4;

  localparam int N_PHASES         = 12;
  localparam int PAIRS_PER_PHASE  = 53;
  localparam int HOLD_PHASE       = 9;
  localparam int PAUSE_PHASE      = 6;
  localparam int LONG_HOLD_CYCLES = 80;
  localparam int SETTLE_CYCLES    = 16;
  localparam int CYCLE_LIMIT      = 200_000;

  localparam logic [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [WORD_BITS-1:0] child_word;
    logic [CUT_W-1:0]     cut_position;
    logic                 parents_identical;
  } child_t;

  typedef struct packed {
    logic [APB_DATA_W-1:0] cfg_word;
    logic [WORD_BITS-1:0]  a;
    logic [WORD_BITS-1:0]  b;
    logic [PICK_W-1:0]     pick;
    logic                  order;
    logic                  known;
    child_t                child;
  } vector_t;

  // cfg word, parent a, parent b, pick, order, known, expected child
  localparam vector_t DIRECTED [21] = '{
    '{32'd64, 64'd0, 64'd0, 32'd0, 1'b0, 1'b1, '{64'd0, 6'd0, 1'b1}},
    '{32'd64, ONES, ONES, 32'hFFFF_FFFF, 1'b1, 1'b1, '{ONES, 6'd0, 1'b1}},
    '{32'd64, 64'd0, ONES, 32'd0, 1'b0, 1'b1, '{ONES, 6'd0, 1'b0}},
    '{32'd64, 64'd0, ONES, 32'd63, 1'b0, 1'b1,
      '{64'h8000_0000_0000_0000, 6'd63, 1'b0}},
    '{32'd64, 64'd0, ONES, 32'hFFFF_FFFF, 1'b1, 1'b1,
      '{64'h7FFF_FFFF_FFFF_FFFF, 6'd63, 1'b0}},
    '{32'd64, 64'd1, 64'd0, 32'h1234_5678, 1'b0, 1'b1, '{64'd0, 6'd0, 1'b0}},
    '{32'd64, 64'h8000_0000_0000_0000, 64'd0, 32'd5, 1'b1, 1'b1,
      '{64'h8000_0000_0000_0000, 6'd63, 1'b0}},
    '{32'd64, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 32'hDEAD_BEEF, 1'b0,
      1'b0, '0},
    '{32'd64, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 32'hDEAD_BEEF, 1'b1,
      1'b0, '0},
    '{32'd64, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 32'h8000_0000, 1'b1,
      1'b0, '0},
    '{32'd64, ONES, 64'd0, 32'd64, 1'b1, 1'b1, '{ONES, 6'd0, 1'b0}},
    // zero width: nothing valid, reported as identical
    '{32'hFFFF_FF80, ONES, 64'd0, 32'd7, 1'b1, 1'b1, '{64'd0, 6'd0, 1'b1}},
    '{32'd1, ONES, 64'hFFFF_FFFF_FFFF_FFFE, 32'd9, 1'b0, 1'b1, '{64'd0, 6'd0, 1'b0}},
    '{32'd1, ONES, 64'hFFFF_FFFF_FFFF_FFFE, 32'd9, 1'b1, 1'b1, '{64'd1, 6'd0, 1'b0}},
    '{32'd1, 64'hFFFF_FFFF_FFFF_FFFE, 64'd0, 32'd3, 1'b0, 1'b1, '{64'd0, 6'd0, 1'b1}},
    // widths above the word saturate
    '{32'd127, 64'd0, ONES, 32'd1, 1'b0, 1'b1,
      '{64'hFFFF_FFFF_FFFF_FFFE, 6'd1, 1'b0}},
    '{32'hABCD_E041, ONES, 64'd0, 32'd64, 1'b0, 1'b1, '{64'd0, 6'd0, 1'b0}},
    '{32'd63, 64'd0, ONES, 32'd62, 1'b0, 1'b1,
      '{64'h4000_0000_0000_0000, 6'd62, 1'b0}},
    '{32'd63, ONES, 64'd0, 32'hFFFF_FFFF, 1'b1, 1'b0, '0},
    '{32'd32, 64'hFFFF_FFFF_0000_0000, 64'h0000_0000_FFFF_FFFF, 32'd31, 1'b0, 1'b0, '0},
    '{32'd2, 64'd2, 64'd1, 32'd1, 1'b0, 1'b0, '0}
  };

  localparam logic [NUM_BITS_W-1:0] PHASE_WIDTHS [N_PHASES] =
    '{7'd127, 7'd0, 7'd1, 7'd2, 7'd7, 7'd31, 7'd32, 7'd33, 7'd63, 7'd64, 7'd65, 7'd5};

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_W-1:0]       in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_W-1:0]      out_tdata;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [APB_ADDR_W-1:0] cfg_paddr;
  logic [APB_DATA_W-1:0] cfg_pwdata;
  logic [APB_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  child_t                child_expect_q[$];
  logic [NUM_BITS_W-1:0] num_bits_q;
  int                    fail_count;
  int                    cycle_count;
  int                    sender_idle_pct;
  int                    recv_idle_pct;
  logic                  long_hold;

  reduced_surrogate_crossover #(
    .WORD_BITS(WORD_BITS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** reduced_surrogate_crossover: FAILED **");
      $finish;
    end
  end

  // crossover predictor: child, cut and identical flag for one parent pair
  function automatic child_t crossover_child(input logic [WORD_BITS-1:0] pa,
                                             input logic [WORD_BITS-1:0] pb,
                                             input logic [PICK_W-1:0] pick,
                                             input logic order,
                                             input logic [NUM_BITS_W-1:0] nb);
    int unsigned          width;
    int unsigned          differing;
    int unsigned          rank;
    int unsigned          cut;
    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] a;
    logic [WORD_BITS-1:0] b;
    logic [WORD_BITS-1:0] diff;
    logic [WORD_BITS-1:0] below;
    logic [WORD_BITS-1:0] first;
    logic [WORD_BITS-1:0] second;
    child_t               r;
    width = (nb > WORD_BITS) ? WORD_BITS : nb;
    mask = '0;
    for (int i = 0; i < width; i++) mask[i] = 1'b1;
    a = pa & mask;
    b = pb & mask;
    diff = a ^ b;
    differing = 0;
    for (int i = 0; i < WORD_BITS; i++) differing += diff[i];
    r = '0;
    if (differing == 0) begin
      r.child_word = a;
      r.parents_identical = 1'b1;
      return r;
    end
    // locate the differing bit whose rank is the pick reduced by the count
    rank = pick % differing;
    cut = 0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (diff[i]) begin
        if (rank == 0) begin
          cut = i;
          break;
        end
        rank--;
      end
    end
    below = '0;
    for (int i = 0; i < cut; i++) below[i] = 1'b1;
    first  = order ? b : a;
    second = order ? a : b;
    r.child_word = ((a & ~diff) | (diff & below & first) | (diff & ~below & second)) & mask;
    r.cut_position = CUT_W'(cut);
    return r;
  endfunction

  // one config port access; reads are checked against the shadow register
  task automatic reg_access(input logic write, input logic [APB_ADDR_W-1:0] addr,
                            input logic [APB_DATA_W-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= write;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (write && addr == NUM_BITS_ADDR) num_bits_q = data[NUM_BITS_W-1:0];
    if (!write && cfg_prdata != APB_DATA_W'(num_bits_q)) begin
      $error("num_bits readback: expected %0d, actual %0d", num_bits_q, cfg_prdata);
      fail_count++;
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // offer one parent pair; queue its child when the transaction is accepted
  task automatic send_pair(input logic [WORD_BITS-1:0] a, input logic [WORD_BITS-1:0] b,
                           input logic [PICK_W-1:0] pick, input logic order,
                           input child_t want);
    logic [IN_W-1:0] word;
    word = '0;
    word[WORD_BITS-1:0]                    = a;
    word[2*WORD_BITS-1:WORD_BITS]          = b;
    word[2*WORD_BITS+PICK_W-1:2*WORD_BITS] = pick;
    word[2*WORD_BITS+PICK_W]               = order;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    child_expect_q.insert(child_expect_q.size(), want);
    @(negedge clk);
  endtask

  // stop offering and wait until every queued child has come out
  task automatic wait_for_children();
    in_tvalid <= 1'b0;
    while (child_expect_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // idle pipeline before touching num_bits
  task automatic drain_pipeline();
    wait_for_children();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // result side: random stalls plus one long hold-off on request
  initial begin
    int hold_left;
    hold_left  = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        hold_left = LONG_HOLD_CYCLES;
        long_hold = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // compare each child transaction with the oldest expectation
  always @(posedge clk) begin
    child_t got;
    child_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.child_word        = out_tdata[WORD_BITS-1:0];
      got.cut_position      = out_tdata[WORD_BITS+CUT_W-1:WORD_BITS];
      got.parents_identical = out_tdata[WORD_BITS+CUT_W];
      if (child_expect_q.size() == 0) begin
        $error("unexpected child transaction: child_word %h", got.child_word);
        fail_count++;
      end else begin
        want = child_expect_q.pop_front();
        if (got.child_word !== want.child_word) begin
          $error("child_word: expected %h, actual %h", want.child_word, got.child_word);
          fail_count++;
        end
        if (got.cut_position !== want.cut_position) begin
          $error("cut_position: expected %0d, actual %0d",
                 want.cut_position, got.cut_position);
          fail_count++;
        end
        if (got.parents_identical !== want.parents_identical) begin
          $error("parents_identical: expected %b, actual %b",
                 want.parents_identical, got.parents_identical);
          fail_count++;
        end
      end
    end
  end

  // stimulus
  initial begin
    vector_t               row;
    child_t                want;
    logic [WORD_BITS-1:0]  a;
    logic [WORD_BITS-1:0]  b;
    logic [WORD_BITS-1:0]  flip;
    logic [PICK_W-1:0]     pick;
    logic                  order;
    logic [NUM_BITS_W-1:0] nb;
    rst_n           = 1'b0;
    in_tvalid       = 1'b0;
    in_tdata        = '0;
    cfg_psel        = 1'b0;
    cfg_penable     = 1'b0;
    cfg_pwrite      = 1'b0;
    cfg_paddr       = '0;
    cfg_pwdata      = '0;
    long_hold       = 1'b0;
    fail_count      = 0;
    num_bits_q      = NUM_BITS_RESET;
    sender_idle_pct = 10;
    recv_idle_pct   = 74;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset value of num_bits
    reg_access(1'b0, NUM_BITS_ADDR, '0);

    // directed table
    foreach (DIRECTED[i]) begin
      row = DIRECTED[i];
      if (row.cfg_word[NUM_BITS_W-1:0] != num_bits_q) begin
        drain_pipeline();
        reg_access(1'b1, NUM_BITS_ADDR, row.cfg_word);
        reg_access(1'b0, NUM_BITS_ADDR, '0);
      end
      want = row.known ? row.child
                       : crossover_child(row.a, row.b, row.pick, row.order, num_bits_q);
      send_pair(row.a, row.b, row.pick, row.order, want);
    end

    // random phases, one num_bits setting each
    for (int ph = 0; ph < N_PHASES; ph++) begin
      if (ph == N_PHASES/3) begin
        sender_idle_pct = 74;
        recv_idle_pct   = 10;
      end
      if (ph == 2*N_PHASES/3) begin
        sender_idle_pct = 0;
        recv_idle_pct   = 0;
      end
      drain_pipeline();
      // a write to an unmapped address must leave num_bits alone
      reg_access(1'b1, UNMAPPED_ADDR, $urandom);
      nb = (ph == N_PHASES-1) ? NUM_BITS_W'($urandom_range(127)) : PHASE_WIDTHS[ph];
      reg_access(1'b1, NUM_BITS_ADDR, ($urandom & 32'hFFFF_FF80) | APB_DATA_W'(nb));
      reg_access(1'b0, NUM_BITS_ADDR, '0);
      for (int k = 0; k < PAIRS_PER_PHASE; k++) begin
        if (ph == HOLD_PHASE && k == 10) long_hold = 1'b1;
        if (ph == PAUSE_PHASE && k == 25) wait_for_children();
        a = {$urandom, $urandom};
        case ($urandom_range(9))
          0: b = a;
          1: begin
            // differences only above the valid width
            flip = {$urandom, $urandom};
            for (int i = 0; i < WORD_BITS; i++) if (i < num_bits_q) flip[i] = 1'b0;
            b = a ^ flip;
          end
          2, 3: begin
            flip = '0;
            repeat ($urandom_range(1, 3)) flip[$urandom_range(WORD_BITS-1)] = 1'b1;
            b = a ^ flip;
          end
          4: b = ~a;
          5: begin
            a = $urandom_range(1) ? ONES : '0;
            b = {$urandom, $urandom};
          end
          default: b = {$urandom, $urandom};
        endcase
        pick  = ($urandom_range(3) == 0) ? PICK_W'($urandom_range(127)) : $urandom;
        order = 1'($urandom_range(1));
        send_pair(a, b, pick, order, crossover_child(a, b, pick, order, num_bits_q));
      end
    end

    // let the last children drain, then watch for strays
    wait_for_children();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("** reduced_surrogate_crossover: PASSED **");
    end else begin
      $display("** reduced_surrogate_crossover: FAILED **");
    end
    $finish;
  end

endmodule

[files.f]
hdl/rsc_pkg.sv
hdl/rsc_front.sv
hdl/rsc_queue.sv
hdl/rsc_back.sv
hdl/reduced_surrogate_crossover.sv
hdl/rsc_checker.sv
sim/tb_reduced_surrogate_crossover.sv
